// File: rtl/cds_pkg.sv
// Shared types, constants and helpers for the calendar date shift core.
package cds_pkg;

  localparam int YEAR_W = 14;
  localparam int DAY_NUM_W = 22;

  localparam logic [YEAR_W-1:0] FIRST_YEAR_RST = 14'd2010;
  localparam logic [YEAR_W-1:0] LAST_YEAR_RST = 14'd2099;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  localparam logic CFG_FIRST_YEAR = 1'b0;
  localparam logic CFG_LAST_YEAR = 1'b1;

  localparam logic [13:0] RECIP_100 = 14'((2**20 + 99) / 100);

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_BAD_DATE = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    status_t status;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    logic [DAY_NUM_W-1:0] day_num;
  } mid_t;

  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [27:0] prod;
    prod = x * RECIP_100;
    return prod[27:20];
  endfunction

  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0: off = 9'd0;
      4'd1: off = 9'd31;
      4'd2: off = 9'd61;
      4'd3: off = 9'd92;
      4'd4: off = 9'd122;
      4'd5: off = 9'd153;
      4'd6: off = 9'd184;
      4'd7: off = 9'd214;
      4'd8: off = 9'd245;
      4'd9: off = 9'd275;
      4'd10: off = 9'd306;
      4'd11: off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// File: rtl/cds_check.sv
// Date validation, window check and day-number shift, three pipeline stages.
module cds_check (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [15:0] in_year,
  input  logic [3:0] in_month,
  input  logic [4:0] in_day,
  input  logic [31:0] in_day_count,
  input  logic in_forward,
  input  logic in_count_from_one,
  input  logic [2:0] in_prior_weekday,
  input  logic [cds_pkg::YEAR_W-1:0] first_year,
  input  logic [cds_pkg::YEAR_W-1:0] last_year,
  output logic mid_valid,
  input  logic mid_stall,
  output cds_pkg::mid_t mid
);

  localparam int NS = 3;
  localparam logic [8:0] DOY_JAN1 = 9'd306;
  localparam logic [8:0] DOY_DEC31 = 9'd305;

  function automatic logic [21:0] day_num(input logic [13:0] yy, input logic [7:0] q,
                                          input logic [8:0] doy);
    logic [21:0] t;
    t = 22'(yy) * 22'd365 + 22'(yy[13:2]) - 22'(q) + 22'(q[7:2]) + 22'(doy);
    return t;
  endfunction

  logic [NS-1:0] v_r;
  logic [NS:0] busy;

  always_comb begin
    busy[NS] = mid_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      busy[k] = v_r[k] && busy[k+1];
    end
  end

  assign in_stall = busy[0];
  assign mid_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (!busy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (!busy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage A
  logic [15:0] a_year_r;
  logic [3:0] a_month_r;
  logic [4:0] a_day_r;
  logic [2:0] a_pw_r;
  logic [31:0] a_cnt_r;
  logic a_fwd_r;
  logic a_c1_r;
  logic [13:0] a_yy_r, a_fy_r, a_fyy_r, a_ly_r;
  logic [7:0] a_q_y_r, a_q_yy_r, a_q_fyy_r, a_q_ly_r;
  logic [3:0] a_mp_r;

  logic [13:0] a_yy_nxt, a_fy_nxt, a_fyy_nxt, a_ly_nxt;
  logic [3:0] a_mp_nxt;

  assign a_yy_nxt = in_year[13:0] - {13'd0, (in_month <= 4'd2)};
  assign a_fy_nxt = (first_year == '0) ? 14'd1 : first_year;
  assign a_ly_nxt = (last_year > cds_pkg::YEAR_MAX) ? cds_pkg::YEAR_MAX : last_year;
  assign a_fyy_nxt = a_fy_nxt - 14'd1;
  assign a_mp_nxt = (in_month > 4'd2) ? in_month - 4'd3 : in_month + 4'd9;

  always_ff @(posedge clk) begin
    if (!busy[0]) begin
      a_year_r <= in_year;
      a_month_r <= in_month;
      a_day_r <= in_day;
      a_pw_r <= in_prior_weekday;
      a_cnt_r <= in_day_count;
      a_fwd_r <= in_forward;
      a_c1_r <= in_count_from_one;
      a_yy_r <= a_yy_nxt;
      a_fy_r <= a_fy_nxt;
      a_fyy_r <= a_fyy_nxt;
      a_ly_r <= a_ly_nxt;
      a_mp_r <= a_mp_nxt;
      a_q_y_r <= cds_pkg::div100(in_year[13:0]);
      a_q_yy_r <= cds_pkg::div100(a_yy_nxt);
      a_q_fyy_r <= cds_pkg::div100(a_fyy_nxt);
      a_q_ly_r <= cds_pkg::div100(a_ly_nxt);
    end
  end

  // stage B
  logic [13:0] b_r100;
  logic b_leap;
  logic [4:0] b_mlen;
  logic b_bad, b_out_win;
  logic [8:0] b_doy;
  cds_pkg::tag_t b_tag_nxt, b_tag_r;
  logic [21:0] b_dn_r, b_lo_r, b_hi_r;
  logic [31:0] b_cnt_nxt, b_cnt_r;
  logic b_fwd_r;

  assign b_r100 = a_year_r[13:0] - 14'(a_q_y_r * 14'd100);
  assign b_leap = ((a_year_r[1:0] == 2'd0) && (b_r100 != 14'd0))
               || ((b_r100 == 14'd0) && (a_q_y_r[1:0] == 2'd0));

  always_comb begin
    case (a_month_r)
      4'd2: b_mlen = b_leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: b_mlen = 5'd30;
      default: b_mlen = 5'd31;
    endcase
  end

  assign b_bad = (a_year_r == 16'd0) || (a_year_r > {2'b00, cds_pkg::YEAR_MAX})
              || (a_month_r == 4'd0) || (a_month_r > 4'd12)
              || (a_day_r == 5'd0) || (a_day_r > b_mlen);
  assign b_out_win = (a_fy_r > a_ly_r) || (a_year_r < {2'b00, a_fy_r})
                  || (a_year_r > {2'b00, a_ly_r});
  assign b_doy = cds_pkg::month_offset(a_mp_r) + 9'(a_day_r) - 9'd1;
  assign b_cnt_nxt = (a_c1_r && (a_cnt_r != 32'd0)) ? a_cnt_r - 32'd1 : a_cnt_r;

  always_comb begin
    b_tag_nxt.year = a_year_r;
    b_tag_nxt.month = a_month_r;
    b_tag_nxt.day = a_day_r;
    b_tag_nxt.weekday = a_pw_r;
    if (b_bad) b_tag_nxt.status = cds_pkg::STATUS_BAD_DATE;
    else if (b_out_win) b_tag_nxt.status = cds_pkg::STATUS_RANGE;
    else b_tag_nxt.status = cds_pkg::STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (!busy[1]) begin
      b_tag_r <= b_tag_nxt;
      b_dn_r <= day_num(a_yy_r, a_q_yy_r, b_doy);
      b_lo_r <= day_num(a_fyy_r, a_q_fyy_r, DOY_JAN1);
      b_hi_r <= day_num(a_ly_r, a_q_ly_r, DOY_DEC31);
      b_cnt_r <= b_cnt_nxt;
      b_fwd_r <= a_fwd_r;
    end
  end

  // stage C
  logic signed [33:0] c_tgt;
  logic c_out;
  cds_pkg::mid_t c_mid_nxt, c_mid_r;

  assign c_tgt = b_fwd_r ? $signed({12'd0, b_dn_r}) + $signed({2'b00, b_cnt_r})
                         : $signed({12'd0, b_dn_r}) - $signed({2'b00, b_cnt_r});
  assign c_out = (c_tgt < $signed({12'd0, b_lo_r})) || (c_tgt > $signed({12'd0, b_hi_r}));

  always_comb begin
    c_mid_nxt.tag = b_tag_r;
    c_mid_nxt.day_num = c_tgt[21:0];
    if (b_tag_r.status == cds_pkg::STATUS_OK && c_out) begin
      c_mid_nxt.tag.status = cds_pkg::STATUS_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy[2]) c_mid_r <= c_mid_nxt;
  end

  assign mid = c_mid_r;

endmodule

// File: rtl/cds_civil.sv
// Day number to civil date and weekday, eight pipeline stages.
module cds_civil (
  input  logic clk,
  input  logic rst_n,
  input  logic mid_valid,
  output logic mid_stall,
  input  cds_pkg::mid_t mid,
  output logic out_valid,
  input  logic out_stall,
  output logic [15:0] out_year,
  output logic [3:0] out_month,
  output logic [4:0] out_day,
  output logic [2:0] out_weekday,
  output logic [1:0] out_status
);

  localparam int NS = 8;
  localparam logic [22:0] RECIP_146097 = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [23:0] RECIP_7 = 24'(((64'd1 << 26) + 64'd6) / 64'd7);
  localparam logic [21:0] RECIP_1460 = 22'(((64'd1 << 32) + 64'd1459) / 64'd1460);
  localparam logic [20:0] RECIP_36524 = 21'(((64'd1 << 36) + 64'd36523) / 64'd36524);
  localparam logic [19:0] RECIP_365 = 20'(((64'd1 << 28) + 64'd364) / 64'd365);
  localparam logic [12:0] RECIP_153 = 13'(((64'd1 << 20) + 64'd152) / 64'd153);

  logic [NS-1:0] v_r;
  logic [NS:0] busy;
  cds_pkg::tag_t tag_r [NS-1];

  always_comb begin
    busy[NS] = out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      busy[k] = v_r[k] && busy[k+1];
    end
  end

  assign mid_stall = busy[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (!busy[0]) v_r[0] <= mid_valid;
      for (int k = 1; k < NS; k++) begin
        if (!busy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy[0]) tag_r[0] <= mid.tag;
    for (int k = 1; k < NS - 1; k++) begin
      if (!busy[k]) tag_r[k] <= tag_r[k-1];
    end
  end

  // stage D: era and mod-7 quotients
  logic [44:0] d_era_prod;
  logic [45:0] d_q7_prod;
  logic [21:0] d_z_r;
  logic [4:0] d_era_r;
  logic [19:0] d_q7_r;

  assign d_era_prod = mid.day_num * RECIP_146097;
  assign d_q7_prod = mid.day_num * RECIP_7;

  always_ff @(posedge clk) begin
    if (!busy[0]) begin
      d_z_r <= mid.day_num;
      d_era_r <= d_era_prod[44:40];
      d_q7_r <= d_q7_prod[45:26];
    end
  end

  // stage E: day of era, weekday
  logic [21:0] e_doe_full, e_rem_full;
  logic [2:0] e_rem;
  logic [17:0] e_doe_r;
  logic [4:0] e_era_r;
  logic [2:0] e_wd_nxt, e_wd_r;

  assign e_doe_full = d_z_r - 22'(d_era_r) * 22'd146097;
  assign e_rem_full = d_z_r - 22'(d_q7_r) * 22'd7;
  assign e_rem = e_rem_full[2:0];
  assign e_wd_nxt = (e_rem >= 3'd4) ? e_rem - 3'd4 : e_rem + 3'd3;

  always_ff @(posedge clk) begin
    if (!busy[1]) begin
      e_doe_r <= e_doe_full[17:0];
      e_era_r <= d_era_r;
      e_wd_r <= e_wd_nxt;
    end
  end

  // stage F: leap corrections
  logic [39:0] f_p1460;
  logic [38:0] f_p36524;
  logic [17:0] f_doe_r;
  logic [7:0] f_q1460_r;
  logic [2:0] f_q36524_r;
  logic f_end_r;
  logic [4:0] f_era_r;
  logic [2:0] f_wd_r;

  assign f_p1460 = e_doe_r * RECIP_1460;
  assign f_p36524 = e_doe_r * RECIP_36524;

  always_ff @(posedge clk) begin
    if (!busy[2]) begin
      f_doe_r <= e_doe_r;
      f_q1460_r <= f_p1460[39:32];
      f_q36524_r <= f_p36524[38:36];
      f_end_r <= (e_doe_r == 18'd146096);
      f_era_r <= e_era_r;
      f_wd_r <= e_wd_r;
    end
  end

  // stage G
  logic [17:0] g_doe_r, g_a_r;
  logic [4:0] g_era_r;
  logic [2:0] g_wd_r;

  always_ff @(posedge clk) begin
    if (!busy[3]) begin
      g_doe_r <= f_doe_r;
      g_a_r <= f_doe_r - 18'(f_q1460_r) + 18'(f_q36524_r) - 18'(f_end_r);
      g_era_r <= f_era_r;
      g_wd_r <= f_wd_r;
    end
  end

  // stage H: year of era
  logic [37:0] h_prod;
  logic [17:0] h_doe_r;
  logic [8:0] h_yoe_r;
  logic [4:0] h_era_r;
  logic [2:0] h_wd_r;

  assign h_prod = g_a_r * RECIP_365;

  always_ff @(posedge clk) begin
    if (!busy[4]) begin
      h_doe_r <= g_doe_r;
      h_yoe_r <= h_prod[36:28];
      h_era_r <= g_era_r;
      h_wd_r <= g_wd_r;
    end
  end

  // stage I: day of year
  logic [17:0] i_ystart, i_doy_full;
  logic [8:0] i_doy_r, i_yoe_r;
  logic [4:0] i_era_r;
  logic [2:0] i_wd_r;

  assign i_ystart = 18'(h_yoe_r) * 18'd365 + 18'(h_yoe_r[8:2])
                  - 18'(cds_pkg::div100(14'(h_yoe_r)));
  assign i_doy_full = h_doe_r - i_ystart;

  always_ff @(posedge clk) begin
    if (!busy[5]) begin
      i_doy_r <= i_doy_full[8:0];
      i_yoe_r <= h_yoe_r;
      i_era_r <= h_era_r;
      i_wd_r <= h_wd_r;
    end
  end

  // stage J: month index
  logic [10:0] j_x;
  logic [23:0] j_prod;
  logic [8:0] j_doy_r, j_yoe_r;
  logic [3:0] j_mp_r;
  logic [4:0] j_era_r;
  logic [2:0] j_wd_r;

  assign j_x = 11'(i_doy_r) * 11'd5 + 11'd2;
  assign j_prod = j_x * RECIP_153;

  always_ff @(posedge clk) begin
    if (!busy[6]) begin
      j_doy_r <= i_doy_r;
      j_yoe_r <= i_yoe_r;
      j_mp_r <= j_prod[23:20];
      j_era_r <= i_era_r;
      j_wd_r <= i_wd_r;
    end
  end

  // stage K: assemble result or echo
  logic [8:0] k_dd_full;
  logic [3:0] k_mm;
  logic [13:0] k_yr;
  cds_pkg::tag_t k_tag_nxt, k_tag_r;

  assign k_dd_full = j_doy_r - cds_pkg::month_offset(j_mp_r) + 9'd1;
  assign k_mm = (j_mp_r < 4'd10) ? j_mp_r + 4'd3 : j_mp_r - 4'd9;
  assign k_yr = 14'(j_yoe_r) + 14'(j_era_r) * 14'd400 + {13'd0, (k_mm <= 4'd2)};

  always_comb begin
    k_tag_nxt = tag_r[NS-2];
    if (tag_r[NS-2].status == cds_pkg::STATUS_OK) begin
      k_tag_nxt.year = {2'b00, k_yr};
      k_tag_nxt.month = k_mm;
      k_tag_nxt.day = k_dd_full[4:0];
      k_tag_nxt.weekday = j_wd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy[7]) k_tag_r <= k_tag_nxt;
  end

  assign out_year = k_tag_r.year;
  assign out_month = k_tag_r.month;
  assign out_day = k_tag_r.day;
  assign out_weekday = k_tag_r.weekday;
  assign out_status = k_tag_r.status;

endmodule

// File: rtl/calendar_date_shift_core.sv
// Top level of the calendar date shift core: window registers and pipeline.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_year in_month in_day in_day_count
//                                           in_forward in_count_from_one in_prior_weekday
//   out      output     out_valid/out_stall out_year out_month out_day out_weekday out_status
//   cfg      input      cfg_we              cfg_index cfg_data
//
// One transfer per cycle sustained while out_stall stays low; each item passes, from input
// transfer to result valid, through the eleven register stages (three for checks and the shift,
// eight for the constant-reciprocal date conversion).
// Reset clears all stage valid bits and loads the window with 2010..2099.
// A stall holds only the stages that are full behind it; empty stages keep filling.
module calendar_date_shift_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [15:0] in_year,
  input  logic [3:0] in_month,
  input  logic [4:0] in_day,
  input  logic [31:0] in_day_count,
  input  logic in_forward,
  input  logic in_count_from_one,
  input  logic [2:0] in_prior_weekday,
  output logic out_valid,
  input  logic out_stall,
  output logic [15:0] out_year,
  output logic [3:0] out_month,
  output logic [4:0] out_day,
  output logic [2:0] out_weekday,
  output logic [1:0] out_status,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [cds_pkg::YEAR_W-1:0] cfg_data
);

  logic [cds_pkg::YEAR_W-1:0] first_year_r, last_year_r;
  logic mid_valid, mid_stall;
  cds_pkg::mid_t mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_year_r <= cds_pkg::FIRST_YEAR_RST;
      last_year_r <= cds_pkg::LAST_YEAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cds_pkg::CFG_FIRST_YEAR: first_year_r <= cfg_data;
        cds_pkg::CFG_LAST_YEAR: last_year_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cds_check u_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_year(in_year),
    .in_month(in_month),
    .in_day(in_day),
    .in_day_count(in_day_count),
    .in_forward(in_forward),
    .in_count_from_one(in_count_from_one),
    .in_prior_weekday(in_prior_weekday),
    .first_year(first_year_r),
    .last_year(last_year_r),
    .mid_valid(mid_valid),
    .mid_stall(mid_stall),
    .mid(mid)
  );

  cds_civil u_civil (
    .clk(clk),
    .rst_n(rst_n),
    .mid_valid(mid_valid),
    .mid_stall(mid_stall),
    .mid(mid),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_year(out_year),
    .out_month(out_month),
    .out_day(out_day),
    .out_weekday(out_weekday),
    .out_status(out_status)
  );

endmodule

// File: sim/calendar_date_shift_core_tb.sv
// Self-checking testbench for calendar_date_shift_core: directed and random date shifts.
module calendar_date_shift_core_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam longint EPOCH_DAY = 719468;
  localparam int EPOCH_WEEKDAY = 4;

  typedef logic [cds_pkg::YEAR_W-1:0] year_cfg_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [31:0] count;
    logic forward;
    logic from_one;
    logic [2:0] prior_wd;
  } shift_req_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    cds_pkg::status_t status;
  } shift_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_year = '0;
  logic [3:0] in_month = '0;
  logic [4:0] in_day = '0;
  logic [31:0] in_day_count = '0;
  logic in_forward = 1'b0;
  logic in_count_from_one = 1'b0;
  logic [2:0] in_prior_weekday = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_year;
  logic [3:0] out_month;
  logic [4:0] out_day;
  logic [2:0] out_weekday;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = cds_pkg::CFG_FIRST_YEAR;
  year_cfg_t cfg_data = '0;

  year_cfg_t win_first = cds_pkg::FIRST_YEAR_RST;
  year_cfg_t win_last = cds_pkg::LAST_YEAR_RST;

  shift_req_t pending_reqs[$];
  shift_res_t expected_dates[$];
  logic req_taken = 1'b0;
  logic calm = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  calendar_date_shift_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_year(in_year),
    .in_month(in_month),
    .in_day(in_day),
    .in_day_count(in_day_count),
    .in_forward(in_forward),
    .in_count_from_one(in_count_from_one),
    .in_prior_weekday(in_prior_weekday),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_year(out_year),
    .out_month(out_month),
    .out_day(out_day),
    .out_weekday(out_weekday),
    .out_status(out_status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int month_days(input longint y, input longint m);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // Days counted from March 1 of year zero.
  function automatic longint civil_to_days(input longint y, input longint m, input longint d);
    longint yy, era, yoe, mp, doy, doe;
    yy = y - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe;
  endfunction

  function automatic void days_to_civil(input longint z, output longint y, output longint m,
                                        output longint d);
    longint era, doe, yoe, doy, mp;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = (mp < 10) ? mp + 3 : mp - 9;
    y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  function automatic longint window_start();
    return (win_first == 0) ? 1 : longint'(win_first);
  endfunction

  function automatic longint window_end();
    return (win_last > cds_pkg::YEAR_MAX) ? longint'(cds_pkg::YEAR_MAX) : longint'(win_last);
  endfunction

  function automatic shift_res_t predict_shift(input shift_req_t r);
    longint fy, ly, lo, hi, n, target, ry, rm, rd;
    shift_res_t res;
    fy = window_start();
    ly = window_end();
    res.year = r.year;
    res.month = r.month;
    res.day = r.day;
    res.weekday = r.prior_wd;
    res.status = cds_pkg::STATUS_OK;
    if (r.year < 1 || r.year > cds_pkg::YEAR_MAX || r.month < 1 || r.month > 12 ||
        r.day < 1 || r.day > month_days(longint'(r.year), longint'(r.month))) begin
      res.status = cds_pkg::STATUS_BAD_DATE;
    end else if (fy > ly || r.year < fy || r.year > ly) begin
      res.status = cds_pkg::STATUS_RANGE;
    end else begin
      lo = civil_to_days(fy, 1, 1);
      hi = civil_to_days(ly, 12, 31);
      n = longint'(r.count);
      if (r.from_one && n > 0) n = n - 1;
      target = civil_to_days(longint'(r.year), longint'(r.month), longint'(r.day)) +
               (r.forward ? n : -n);
      if (target < lo || target > hi) begin
        res.status = cds_pkg::STATUS_RANGE;
      end else begin
        days_to_civil(target, ry, rm, rd);
        res.year = ry[15:0];
        res.month = rm[3:0];
        res.day = rd[4:0];
        res.weekday = 3'((target % 7 + 7 - EPOCH_DAY % 7 + EPOCH_WEEKDAY) % 7);
      end
    end
    return res;
  endfunction

  task automatic add_req(input logic [15:0] y, input logic [3:0] m, input logic [4:0] d,
                         input logic [31:0] n, input logic fwd, input logic cfo,
                         input logic [2:0] pw);
    shift_req_t r;
    r.year = y;
    r.month = m;
    r.day = d;
    r.count = n;
    r.forward = fwd;
    r.from_one = cfo;
    r.prior_wd = pw;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random_reqs(input int cnt);
    shift_req_t r;
    longint fy, ly, span, dn;
    int kind;
    for (int i = 0; i < cnt; i++) begin
      fy = window_start();
      ly = window_end();
      r.forward = 1'($urandom_range(1));
      r.from_one = 1'($urandom_range(1));
      r.prior_wd = 3'($urandom_range(7));
      kind = $urandom_range(99);
      if (kind < 10) begin
        r.year = 16'($urandom_range(65535));
        r.month = 4'($urandom_range(15));
        r.day = 5'($urandom_range(31));
        r.count = $urandom;
      end else begin
        if (fy > ly || kind < 18) begin
          r.year = 16'($urandom_range(cds_pkg::YEAR_MAX, 1));
          r.month = 4'($urandom_range(12, 1));
          r.day = 5'($urandom_range(month_days(longint'(r.year), longint'(r.month)), 1));
        end else if (kind < 28) begin
          r.year = (kind < 23) ? fy[15:0] : ly[15:0];
          r.month = (kind < 23) ? 4'd1 : 4'd12;
          r.day = (kind < 23) ? 5'd1 : 5'd31;
        end else begin
          r.year = 16'($urandom_range(int'(ly), int'(fy)));
          r.month = 4'($urandom_range(12, 1));
          r.day = 5'($urandom_range(month_days(longint'(r.year), longint'(r.month)), 1));
        end
        span = (fy > ly) ? 400 : (ly - fy + 1) * 366;
        case ($urandom_range(9))
          0, 1, 2, 3: r.count = $urandom_range(400);
          4, 5, 6: r.count = $urandom_range(int'(span));
          7: r.count = $urandom;
          8: r.count = $urandom_range(3);
          default: begin
            if (fy <= ly && r.year >= fy && r.year <= ly) begin
              dn = civil_to_days(longint'(r.year), longint'(r.month), longint'(r.day));
              r.count = r.forward ? 32'(civil_to_days(ly, 12, 31) - dn + $urandom_range(1))
                                  : 32'(dn - civil_to_days(fy, 1, 1) + $urandom_range(1));
            end else begin
              r.count = $urandom_range(10);
            end
          end
        endcase
      end
      pending_reqs.push_back(r);
    end
  endtask

  task automatic write_window(input year_cfg_t fy_val, input year_cfg_t ly_val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= cds_pkg::CFG_FIRST_YEAR;
    cfg_data <= fy_val;
    win_first = fy_val;
    @(negedge clk);
    cfg_index <= cds_pkg::CFG_LAST_YEAR;
    cfg_data <= ly_val;
    win_last = ly_val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_dates.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic send_idle();
    return !calm && ($urandom_range(99) < 16);
  endfunction

  // Hold a stalled transfer, otherwise advance to the next pending item.
  always @(negedge clk) begin
    shift_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && !send_idle()) begin
        r = pending_reqs.pop_front();
        in_year <= r.year;
        in_month <= r.month;
        in_day <= r.day;
        in_day_count <= r.count;
        in_forward <= r.forward;
        in_count_from_one <= r.from_one;
        in_prior_weekday <= r.prior_wd;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 16);
  end

  always @(posedge clk) begin
    shift_req_t r;
    shift_res_t got, want;
    req_taken = rst_n && in_valid && !in_stall;
    if (req_taken) begin
      r = {in_year, in_month, in_day, in_day_count, in_forward, in_count_from_one,
           in_prior_weekday};
      expected_dates.push_back(predict_shift(r));
    end
    if (rst_n && out_valid && !out_stall) begin
      got.year = out_year;
      got.month = out_month;
      got.day = out_day;
      got.weekday = out_weekday;
      got.status = cds_pkg::status_t'(out_status);
      if (expected_dates.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result %0d-%0d-%0d wd %0d status %0d", got.year, got.month,
                   got.day, got.weekday, got.status);
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
            got.weekday !== want.weekday || got.status !== want.status) begin
          if (mismatches < 10)
            $display("mismatch: exp %0d-%0d-%0d wd %0d st %0d, got %0d-%0d-%0d wd %0d st %0d",
                     want.year, want.month, want.day, want.weekday, want.status,
                     got.year, got.month, got.day, got.weekday, got.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    year_cfg_t yr;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_req(2010, 1, 1, 0, 1, 0, 0);
    add_req(2010, 1, 1, 1, 0, 0, 0);
    add_req(2099, 12, 31, 1, 1, 0, 0);
    add_req(2099, 12, 31, 1, 1, 1, 0);
    add_req(2050, 6, 15, 0, 0, 1, 3);
    add_req(2050, 6, 15, 32'hFFFF_FFFF, 1, 0, 5);
    add_req(2050, 6, 15, 32'hFFFF_FFFF, 0, 1, 7);
    add_req(2012, 2, 29, 366, 1, 0, 2);
    add_req(2011, 2, 29, 1, 1, 0, 7);
    add_req(2100, 2, 29, 1, 0, 0, 6);
    add_req(2000, 2, 29, 1, 1, 0, 1);
    add_req(0, 1, 1, 0, 1, 0, 4);
    add_req(16'hFFFF, 15, 31, 32'hFFFF_FFFF, 1, 1, 7);
    add_req(2020, 0, 10, 5, 1, 0, 0);
    add_req(2020, 13, 10, 5, 1, 0, 0);
    add_req(2020, 4, 31, 5, 0, 0, 0);
    add_req(2020, 1, 0, 5, 0, 0, 0);
    add_req(2020, 1, 31, 1, 1, 0, 0);
    add_req(2009, 12, 31, 1, 1, 0, 0);
    add_random_reqs(300);
    drain();

    write_window(1, cds_pkg::YEAR_MAX);
    add_req(1, 1, 1, 1, 0, 0, 0);
    add_req(9999, 12, 31, 1, 1, 0, 0);
    add_req(1, 1, 1, 3652058, 1, 0, 0);
    add_req(9999, 12, 31, 3652059, 0, 1, 0);
    add_req(10000, 1, 1, 0, 1, 0, 0);
    add_req(1600, 2, 29, 146097, 1, 0, 0);
    add_random_reqs(450);
    drain();

    calm = 1'b1;
    write_window(0, 14'h3FFF);
    add_random_reqs(300);
    drain();
    calm = 1'b0;

    write_window(14'h3FFF, 0);
    add_random_reqs(80);
    drain();

    yr = year_cfg_t'($urandom_range(cds_pkg::YEAR_MAX, 1));
    write_window(yr, yr);
    add_random_reqs(200);
    drain();

    yr = year_cfg_t'($urandom_range(cds_pkg::YEAR_MAX, 1));
    write_window(yr, (yr + 14'd60 > cds_pkg::YEAR_MAX) ? cds_pkg::YEAR_MAX
                                                         : yr + year_cfg_t'($urandom_range(60)));
    add_random_reqs(300);
    drain();

    write_window(cds_pkg::FIRST_YEAR_RST, cds_pkg::LAST_YEAR_RST);
    add_random_reqs(300);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: calendar_date_shift_core.f
rtl/cds_pkg.sv
rtl/cds_check.sv
rtl/cds_civil.sv
rtl/calendar_date_shift_core.sv
sim/calendar_date_shift_core_tb.sv
